[hdl/swtq_pkg.sv]
package swtq_pkg;

    localparam int DEPTH     = 8;
    localparam int TASK_W    = 3;
    localparam int DELAY_W   = 31;
    localparam int NOW_W     = 47;
    localparam int TIME_W    = 48;
    localparam int PCOUNT_W  = 4;

    // one entry per task at most, so storage beyond the task count is never used
    localparam int CAP       = (DEPTH < (1 << TASK_W)) ? DEPTH : (1 << TASK_W);
    localparam int CNT_W     = $clog2(CAP + 1);
    localparam int ADDR_W    = $clog2(CAP);
    localparam int SUM_W     = TIME_W + 1;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic MODE_SCHED = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef struct packed {
        logic load;
        logic rm_step;
        logic rm_end;
        logic ins_step;
        logic pop;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic rm_more;
        logic full;
        logic ins_place;
        logic out_free;
    } t_stat;

endpackage

[hdl/swtq_dp.sv]
module swtq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swtq_pkg::t_cmd                i_cmd,
    output swtq_pkg::t_stat               o_stat,
    input  logic                          i_mode,
    input  logic [swtq_pkg::TASK_W-1:0]   i_task_id,
    input  logic                          i_from_main,
    input  logic [swtq_pkg::DELAY_W-1:0]  i_delay_ms,
    input  logic [swtq_pkg::NOW_W-1:0]    i_now_ms,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_wake_valid,
    output logic [swtq_pkg::TASK_W-1:0]   o_wake_id,
    output logic                          o_status,
    output logic [swtq_pkg::PCOUNT_W-1:0] o_pending_count
);
    import swtq_pkg::*;

    // queue storage, packed: slots below r_count are live, in queue order
    logic [TASK_W-1:0] r_task [CAP];
    logic [TIME_W-1:0] r_wake [CAP];

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic              r_found;

    logic [TASK_W-1:0] r_new_task;
    logic [TIME_W-1:0] r_new_wake;
    logic [NOW_W-1:0]  r_now;

    logic              r_res_wv;
    logic [TASK_W-1:0] r_res_id;
    logic              r_res_status;

    logic                r_out_valid;
    logic                r_out_wv;
    logic [TASK_W-1:0]   r_out_id;
    logic                r_out_status;
    logic [PCOUNT_W-1:0] r_out_count;

    logic [SUM_W-1:0]  sum;
    logic [TIME_W-1:0] wake_sat;
    logic [CNT_W-1:0]  idx_m1;
    logic [ADDR_W-1:0] rd_addr;
    logic [TASK_W-1:0] rd_task;
    logic [TIME_W-1:0] rd_wake;
    logic              pop_hit;
    logic [CNT_W-1:0]  count_left;

    assign sum      = SUM_W'(i_now_ms) + SUM_W'(i_delay_ms);
    assign wake_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    // removal reads the current slot, insertion the one in front of it
    assign idx_m1  = r_idx - CNT_W'(1);
    assign rd_addr = i_cmd.ins_step ? idx_m1[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign rd_task = r_task[rd_addr];
    assign rd_wake = r_wake[rd_addr];

    assign pop_hit    = (r_count != '0) && (r_wake[0] <= {1'b0, r_now});
    assign count_left = r_count - CNT_W'(r_found);

    always_comb begin
        o_stat.rm_more   = r_idx < r_count;
        o_stat.full      = r_count == CNT_W'(CAP);
        o_stat.ins_place = (r_idx == '0) || !(rd_wake > r_new_wake);
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.rm_step) begin
                r_idx <= r_idx + CNT_W'(1);
                if (rd_task == r_new_task) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.rm_end) begin
                r_count <= count_left;
                r_idx   <= count_left;
            end
            if (i_cmd.ins_step) begin
                if (o_stat.ins_place) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_idx <= idx_m1;
                end
            end
            if (i_cmd.pop && pop_hit) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new_task   <= i_task_id;
            r_new_wake   <= wake_sat;
            r_now        <= i_now_ms;
            r_res_wv     <= 1'b0;
            r_res_id     <= '0;
            r_res_status <= (i_mode == MODE_SCHED) && i_from_main;
        end
        // close the gap left by the removed entry, one slot per step
        if (i_cmd.rm_step && r_found) begin
            r_task[idx_m1[ADDR_W-1:0]] <= rd_task;
            r_wake[idx_m1[ADDR_W-1:0]] <= rd_wake;
        end
        // insertion walks from the tail, moving later wakeups back
        if (i_cmd.ins_step) begin
            if (o_stat.ins_place) begin
                r_task[r_idx[ADDR_W-1:0]] <= r_new_task;
                r_wake[r_idx[ADDR_W-1:0]] <= r_new_wake;
            end else begin
                r_task[r_idx[ADDR_W-1:0]] <= rd_task;
                r_wake[r_idx[ADDR_W-1:0]] <= rd_wake;
            end
        end
        if (i_cmd.pop && pop_hit) begin
            r_res_wv <= 1'b1;
            r_res_id <= r_task[0];
            for (int i = 0; i < CAP - 1; i++) begin
                r_task[i] <= r_task[i+1];
                r_wake[i] <= r_wake[i+1];
            end
        end
        if (i_cmd.emit) begin
            r_out_wv     <= r_res_wv;
            r_out_id     <= r_res_id;
            r_out_status <= r_res_status;
            r_out_count  <= PCOUNT_W'(r_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_wake_valid    = r_out_wv;
    assign o_wake_id       = r_out_id;
    assign o_status        = r_out_status;
    assign o_pending_count = r_out_count;

endmodule

[hdl/swtq_ctrl.sv]
module swtq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_mode,
    input  logic             i_from_main,
    input  swtq_pkg::t_stat  i_stat,
    output logic             o_in_stall,
    output swtq_pkg::t_cmd   o_cmd
);
    import swtq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RM,
        S_INS,
        S_POP,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = r_state != S_IDLE;
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_mode == MODE_TICK) begin
                        n_state = S_POP;
                    end else if (i_from_main) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_RM;
                    end
                end
            end
            S_RM: begin
                if (i_stat.rm_more) begin
                    o_cmd.rm_step = 1'b1;
                end else begin
                    o_cmd.rm_end = 1'b1;
                    n_state      = S_INS;
                end
            end
            S_INS: begin
                // a full queue drops the new entry
                if (i_stat.full) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.ins_step = 1'b1;
                    if (i_stat.ins_place) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/sorted_wakeup_timer_queue.sv]
// Sorted wakeup timer queue. Holds at most one pending wakeup per task, kept
// in ascending order of wakeup time with earlier insertions first among equal
// times. A schedule word (mode 0) drops the task's pending entry, then inserts
// now_ms + delay_ms (saturated to 48 bits); from_main set rejects it with
// status 1 and leaves the queue alone. A tick word (mode 1) pops the head if
// its wakeup is not later than now_ms and reports it as a wake, one at most
// per tick. Every input word gives exactly one result word carrying the
// number of entries left queued. One word is worked on at a time: the queue
// is walked one stored entry per cycle, first forward to close the gap of the
// old entry, then backward from the tail to find the insertion slot. With a
// full queue of eight the task's old entry is always present and removed.
// The next word is held off by o_in_stall until the result word has moved
// into the output register.

module sorted_wakeup_timer_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [swtq_pkg::TASK_W-1:0]   i_task_id,
    input  logic                          i_from_main,
    input  logic [swtq_pkg::DELAY_W-1:0]  i_delay_ms,
    input  logic [swtq_pkg::NOW_W-1:0]    i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_wake_valid,
    output logic [swtq_pkg::TASK_W-1:0]   o_wake_id,
    output logic                          o_status,
    output logic [swtq_pkg::PCOUNT_W-1:0] o_pending_count
);
    import swtq_pkg::*;

    // command and status between the sequencer and the queue datapath
    t_cmd  cmd;
    t_stat stat;

    swtq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_from_main (i_from_main),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    // datapath captures the input word on the load command, so the input
    // side is free again once the controller is back in its idle state
    swtq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_mode          (i_mode),
        .i_task_id       (i_task_id),
        .i_from_main     (i_from_main),
        .i_delay_ms      (i_delay_ms),
        .i_now_ms        (i_now_ms),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_wake_valid    (o_wake_valid),
        .o_wake_id       (o_wake_id),
        .o_status        (o_status),
        .o_pending_count (o_pending_count)
    );

endmodule

[hdl/swtq_chk.sv]
module swtq_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_mode,
    input logic [2:0]  i_task_id,
    input logic        i_from_main,
    input logic [30:0] i_delay_ms,
    input logic [46:0] i_now_ms,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_wake_valid,
    input logic [2:0]  o_wake_id,
    input logic        o_status,
    input logic [3:0]  o_pending_count
);

    // one word at a time: an accepted word holds off the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a word is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_wake_valid)
        && $stable(o_wake_id) && $stable(o_status) && $stable(o_pending_count))
        else $error("stalled result word changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pending_count <= 4'd8)
        else $error("pending count above task count");

    a_wake_no_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wake_valid |-> !o_status)
        else $error("wake reported alongside a rejection");

    a_wake_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_wake_valid |-> o_wake_id == 3'd0)
        else $error("wake id set without a wake");

endmodule

bind sorted_wakeup_timer_queue swtq_chk u_chk (.*);

[dv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swtq_pkg::*;

    // run shape
    localparam int RANDOM_WORDS   = 1330;
    localparam int HOLD_AT_WORD   = 600;   // receiver hold-off starts around here
    localparam int HOLD_CYCLES    = 400;
    localparam int BURST_FIRST    = 900;   // stretch with no idling on either side
    localparam int BURST_LAST     = 1100;
    localparam int IDLE_PERCENT   = 22;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
    localparam logic [NOW_W-1:0]   NOW_MAX   = '1;

    // one result word as the block reports it
    typedef struct packed {
        logic                wake_valid;
        logic [TASK_W-1:0]   wake_id;
        logic                status;
        logic [PCOUNT_W-1:0] pending;
    } wake_result_t;

    // one row of the directed table; want is only used when typed is set
    typedef struct packed {
        logic               mode;
        logic [TASK_W-1:0]  tid;
        logic               main_req;
        logic [DELAY_W-1:0] dly;
        logic [NOW_W-1:0]   now_v;
        logic               typed;
        wake_result_t       want;
    } stim_row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_mode = MODE_TICK;
    logic [TASK_W-1:0]   i_task_id = '0;
    logic                i_from_main = 1'b0;
    logic [DELAY_W-1:0]  i_delay_ms = '0;
    logic [NOW_W-1:0]    i_now_ms = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_wake_valid;
    logic [TASK_W-1:0]   o_wake_id;
    logic                o_status;
    logic [PCOUNT_W-1:0] o_pending_count;

    sorted_wakeup_timer_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_task_id       (i_task_id),
        .i_from_main     (i_from_main),
        .i_delay_ms      (i_delay_ms),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_wake_valid    (o_wake_valid),
        .o_wake_id       (o_wake_id),
        .o_status        (o_status),
        .o_pending_count (o_pending_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shared between the sender, the receiver and the checker
    wake_result_t wake_results_due[$];
    stim_row_t    dir_rows[$];
    int           err_count     = 0;
    int           words_checked = 0;
    bit           no_idle       = 1'b0;
    bit           hold_request  = 1'b0;
    int           quiet_cycles  = 0;

    // ------------------------------------------------------------------
    // Predicted queue: packed, slots 0..len-1 in wake order
    // ------------------------------------------------------------------
    logic [TASK_W-1:0] sleeper_task[DEPTH];
    logic [TIME_W-1:0] sleeper_wake[DEPTH];
    int                sleeper_len = 0;

    // close the gap left by the entry at pos
    function automatic void drop_sleeper(input int pos);
        for (int i = pos; i + 1 < sleeper_len; i++) begin
            sleeper_task[i] = sleeper_task[i + 1];
            sleeper_wake[i] = sleeper_wake[i + 1];
        end
        sleeper_len--;
    endfunction

    // works out the result word of one accepted word and updates the queue
    function automatic wake_result_t predict_wake(
        input logic               mode,
        input logic [TASK_W-1:0]  tid,
        input logic               main_req,
        input logic [DELAY_W-1:0] dly,
        input logic [NOW_W-1:0]   now_v
    );
        wake_result_t      r;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] wake;
        int                pos;
        r = '0;
        if (mode == MODE_SCHED) begin
            if (main_req) begin
                r.status = 1'b1;           // rejected, queue untouched
            end else begin
                sum  = now_v + dly;
                wake = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
                // at most one entry per task: drop the old one first
                for (int i = 0; i < sleeper_len; i++) begin
                    if (sleeper_task[i] == tid) begin
                        drop_sleeper(i);
                        break;
                    end
                end
                if (sleeper_len < DEPTH) begin
                    // behind every entry not later than the new one
                    pos = 0;
                    while (pos < sleeper_len && sleeper_wake[pos] <= wake)
                        pos++;
                    for (int i = sleeper_len; i > pos; i--) begin
                        sleeper_task[i] = sleeper_task[i - 1];
                        sleeper_wake[i] = sleeper_wake[i - 1];
                    end
                    sleeper_task[pos] = tid;
                    sleeper_wake[pos] = wake;
                    sleeper_len++;
                end
            end
        end else if (sleeper_len > 0 && sleeper_wake[0] <= now_v) begin
            r.wake_valid = 1'b1;
            r.wake_id    = sleeper_task[0];
            drop_sleeper(0);
        end
        r.pending = PCOUNT_W'(sleeper_len);
        return r;
    endfunction

    function automatic void add_row(
        input logic               mode,
        input logic [TASK_W-1:0]  tid,
        input logic               main_req,
        input logic [DELAY_W-1:0] dly,
        input logic [NOW_W-1:0]   now_v,
        input logic               typed,
        input wake_result_t       want
    );
        dir_rows.push_back('{mode, tid, main_req, dly, now_v, typed, want});
    endfunction

    // Offer one word from a falling edge and hold it until taken. Returns at
    // the falling edge after acceptance, so valid is only ever written once
    // per edge.
    task automatic send_word(input stim_row_t w);
        wake_result_t predicted;
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= w.mode;
        i_task_id   <= w.tid;
        i_from_main <= w.main_req;
        i_delay_ms  <= w.dly;
        i_now_ms    <= w.now_v;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = predict_wake(w.mode, w.tid, w.main_req, w.dly, w.now_v);
        wake_results_due.push_back(w.typed ? w.want : predicted);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("word %0d: %s mismatch, expected %0d got %0d",
                 words_checked, what, want, got);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: reset, directed table, then random traffic
    // ------------------------------------------------------------------
    initial begin : sender
        stim_row_t         w;
        logic [NOW_W-1:0]  time_base;
        int                pick;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue, rejection, due at once, far future
        add_row(MODE_TICK,  3'd0, 1'b0, '0, '0, 1'b1, '{1'b0, 3'd0, 1'b0, 4'd0});
        add_row(MODE_SCHED, 3'd7, 1'b1, DELAY_MAX, NOW_MAX, 1'b1,
                '{1'b0, 3'd0, 1'b1, 4'd0});
        add_row(MODE_SCHED, 3'd0, 1'b0, '0, '0, 1'b1, '{1'b0, 3'd0, 1'b0, 4'd1});
        add_row(MODE_TICK,  3'd5, 1'b1, DELAY_MAX, '0, 1'b1,
                '{1'b1, 3'd0, 1'b0, 4'd0});
        // widest sum the fields allow; the new entry is never due after this
        add_row(MODE_SCHED, 3'd7, 1'b0, DELAY_MAX, NOW_MAX, 1'b1,
                '{1'b0, 3'd0, 1'b0, 4'd1});
        add_row(MODE_TICK,  3'd0, 1'b0, '0, NOW_MAX, 1'b1, '{1'b0, 3'd0, 1'b0, 4'd1});
        // equal wakeups keep insertion order, reschedule moves a task
        add_row(MODE_SCHED, 3'd1, 1'b0, 31'd10, 47'd100, 1'b0, '0);
        add_row(MODE_SCHED, 3'd2, 1'b0, 31'd10, 47'd100, 1'b0, '0);
        add_row(MODE_SCHED, 3'd3, 1'b0, 31'd5,  47'd100, 1'b0, '0);
        add_row(MODE_SCHED, 3'd1, 1'b0, 31'd0,  47'd200, 1'b0, '0);
        add_row(MODE_SCHED, 3'd2, 1'b1, 31'd0,  47'd0,   1'b0, '0);
        add_row(MODE_TICK,  3'd0, 1'b0, '0, 47'd104, 1'b0, '0);
        add_row(MODE_TICK,  3'd0, 1'b0, '0, 47'd105, 1'b0, '0);
        add_row(MODE_TICK,  3'd0, 1'b0, '0, 47'd1000, 1'b0, '0);
        add_row(MODE_TICK,  3'd0, 1'b0, '0, 47'd1000, 1'b0, '0);
        // fill all eight slots, then reschedule into a full queue
        for (int t = 0; t < 7; t++)
            add_row(MODE_SCHED, TASK_W'(t), 1'b0, DELAY_W'(700 - 90 * t), 47'd2000,
                    1'b0, '0);
        add_row(MODE_SCHED, 3'd4, 1'b0, '0, '0, 1'b0, '0);
        add_row(MODE_TICK,  3'd0, 1'b0, '0, '0, 1'b0, '0);

        foreach (dir_rows[k])
            send_word(dir_rows[k]);

        // Random part: a running clock that mostly moves forward, so that
        // schedules come due on later ticks; now and then a jump or a
        // stray time value as noise.
        time_base = 47'd3000;
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k == HOLD_AT_WORD)
                hold_request = 1'b1;
            no_idle = (k >= BURST_FIRST && k < BURST_LAST);

            pick = $urandom_range(99);
            if (pick < 3)
                time_base = NOW_W'({$urandom, $urandom});
            else
                time_base = time_base + NOW_W'($urandom_range(12));

            w.typed    = 1'b0;
            w.want     = '0;
            w.mode     = ($urandom_range(99) < 45) ? MODE_TICK : MODE_SCHED;
            w.tid      = TASK_W'($urandom_range(7));
            w.main_req = ($urandom_range(99) < 10);
            pick = $urandom_range(99);
            if (pick < 65)
                w.dly = DELAY_W'($urandom_range(40));
            else if (pick < 85)
                w.dly = DELAY_W'($urandom_range(5000));
            else if (pick < 95)
                w.dly = DELAY_W'($urandom);
            else
                w.dly = DELAY_MAX;
            w.now_v = ($urandom_range(99) < 5) ? NOW_W'({$urandom, $urandom}) : time_base;
            send_word(w);
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;

        while (wake_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && wake_results_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, plus one long hold-off so the block backs up
    // into its input while the sender keeps offering words
    // ------------------------------------------------------------------
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: each result word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        wake_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (wake_results_due.size() == 0) begin
                $display("word %0d: result word with nothing expected", words_checked);
                err_count++;
            end else begin
                want = wake_results_due.pop_front();
                if (o_wake_valid !== want.wake_valid)
                    report_mismatch("wake_valid", want.wake_valid, o_wake_valid);
                if (o_wake_id !== want.wake_id)
                    report_mismatch("wake_id", want.wake_id, o_wake_id);
                if (o_status !== want.status)
                    report_mismatch("status", want.status, o_status);
                if (o_pending_count !== want.pending)
                    report_mismatch("pending_count", want.pending, o_pending_count);
            end
            words_checked++;
        end
    end

    // watchdog: cycles in which neither side moves a word
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
